// File: rtl/flash_backup_command_fsm_unit_defines.svh
// assertion macros used by the checker file
`ifndef FLASH_BACKUP_COMMAND_FSM_UNIT_DEFINES_SVH
`define FLASH_BACKUP_COMMAND_FSM_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbc assertion failed");

// next-cycle implication, disabled during reset
`define FBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbc assertion failed");

`endif

// File: rtl/fbc_pkg.sv
// shared constants and controller/datapath interface types
package fbc_pkg;

	localparam int FBC_MEMORY_BYTES = 65536;
	localparam int FBC_SECTOR_BYTES = 4096;
	localparam int FBC_SECT_W       = $clog2(FBC_SECTOR_BYTES);

	localparam logic [15:0] ADDR_CMD1 = 16'h5555;
	localparam logic [15:0] ADDR_CMD2 = 16'h2AAA;

	localparam logic [7:0] CMD_UNLOCK1   = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2   = 8'h55;
	localparam logic [7:0] CMD_ID_ENTER  = 8'h90;
	localparam logic [7:0] CMD_ID_EXIT   = 8'hF0;
	localparam logic [7:0] CMD_ERASE     = 8'h80;
	localparam logic [7:0] CMD_CHIP_ERS  = 8'h10;
	localparam logic [7:0] CMD_SECT_ERS  = 8'h30;
	localparam logic [7:0] CMD_PROGRAM   = 8'hA0;
	localparam logic [7:0] CMD_BANK      = 8'hB0;

	localparam logic [7:0] ID_MFR_64K  = 8'h32;
	localparam logic [7:0] ID_DEV_64K  = 8'h1B;
	localparam logic [7:0] ID_MFR_128K = 8'h62;
	localparam logic [7:0] ID_DEV_128K = 8'h13;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	// controller to datapath
	typedef struct packed {
		logic capture;     // latch the incoming request, read the store
		logic prog_we;     // program the latched byte
		logic sweep_load;  // start an erase sweep
		logic sweep_full;  // whole store instead of one sector
		logic sweep_step;  // write one erased byte, advance
		logic id_mode;     // chip-id mode active
		logic size_sel;    // 128K part identity
	} fbc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       is_write;
		logic       addr_cmd1;
		logic       addr_cmd2;
		logic       addr_zero;
		logic [7:0] data;
		logic       sweep_last;
	} fbc_status_t;

endpackage

// File: rtl/fbc_datapath.sv
// request latch, byte store, erase sweep counter and read mux
module fbc_datapath
	import fbc_pkg::*;
#(
	parameter int MEMORY_BYTES = FBC_MEMORY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  fbc_cmd_t    cmd,
	output fbc_status_t status,
	output logic [7:0]  read_data
);

	localparam int ADDR_W = $clog2(MEMORY_BYTES);

	logic [7:0]        mem [MEMORY_BYTES];
	logic              is_write_q;
	logic [15:0]       addr_q;
	logic [7:0]        data_q;
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              full_q;
	logic [ADDR_W-1:0] sect_base;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;

	assign sect_base = ADDR_W'({addr_q[15:FBC_SECT_W], {FBC_SECT_W{1'b0}}});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_write_q <= command;
			addr_q     <= address;
			data_q     <= data;
			rdata_q    <= mem[ADDR_W'(address)];
		end
	end

	// sweep counter starts as a full clear out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			full_q <= 1'b1;
		end else if (cmd.sweep_load) begin
			cnt_q  <= cmd.sweep_full ? '0 : sect_base;
			full_q <= cmd.sweep_full;
		end else if (cmd.sweep_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign waddr = cmd.sweep_step ? cnt_q : ADDR_W'(addr_q);
	assign wdata = cmd.sweep_step ? ERASED_BYTE : data_q;

	always_ff @(posedge clk) begin
		if (cmd.sweep_step || cmd.prog_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_comb begin
		status.is_write   = is_write_q;
		status.addr_cmd1  = (addr_q == ADDR_CMD1);
		status.addr_cmd2  = (addr_q == ADDR_CMD2);
		status.addr_zero  = (addr_q == 16'd0);
		status.data       = data_q;
		status.sweep_last = full_q ? (cnt_q == ADDR_W'(MEMORY_BYTES - 1))
		                           : (&cnt_q[FBC_SECT_W-1:0]);
	end

	always_comb begin
		read_data = rdata_q;
		if (cmd.id_mode && addr_q == 16'd0) begin
			read_data = cmd.size_sel ? ID_MFR_128K : ID_MFR_64K;
		end else if (cmd.id_mode && addr_q == 16'd1) begin
			read_data = cmd.size_sel ? ID_DEV_128K : ID_DEV_64K;
		end
	end

endmodule

// File: rtl/fbc_controller.sv
// sequencer and flash command mode state machine
module fbc_controller
	import fbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        cfg_valid,
	input  logic        cfg_data,
	input  fbc_status_t status,
	output fbc_cmd_t    cmd,
	output logic        busy,
	output logic        read_valid
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP
	} state_t;

	typedef enum logic [2:0] {
		M_READY,
		M_UNLOCK1,
		M_UNLOCK2,
		M_CHIPID,
		M_ERASEPREP,
		M_WRITEPREP,
		M_BANK
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   size_sel_q;

	always_comb begin
		state_d        = state_q;
		mode_d         = mode_q;
		cmd            = '0;
		cmd.id_mode    = (mode_q == M_CHIPID);
		cmd.size_sel   = size_sel_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.capture = start;
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				if (status.is_write) begin
					if (mode_q == M_WRITEPREP) begin
						cmd.prog_we = 1'b1;
						mode_d      = M_READY;
					end else if (mode_q == M_ERASEPREP && status.data == CMD_SECT_ERS) begin
						cmd.sweep_load = 1'b1;
						mode_d         = M_READY;
						state_d        = ST_SWEEP;
					end else if (mode_q == M_BANK && status.addr_zero) begin
						mode_d = M_READY;
					end else if (status.addr_cmd1) begin
						case (status.data)
							CMD_UNLOCK1: begin
								if (mode_q == M_READY) mode_d = M_UNLOCK1;
							end
							CMD_ID_ENTER: begin
								if (mode_q == M_UNLOCK2) mode_d = M_CHIPID;
							end
							CMD_ID_EXIT: begin
								if (mode_q == M_CHIPID) mode_d = M_READY;
							end
							CMD_ERASE: begin
								if (mode_q == M_UNLOCK2) mode_d = M_ERASEPREP;
							end
							CMD_CHIP_ERS: begin
								if (mode_q == M_ERASEPREP) begin
									cmd.sweep_load = 1'b1;
									cmd.sweep_full = 1'b1;
									mode_d         = M_READY;
									state_d        = ST_SWEEP;
								end
							end
							CMD_PROGRAM: begin
								if (mode_q == M_UNLOCK2) mode_d = M_WRITEPREP;
							end
							CMD_BANK: begin
								if (size_sel_q && mode_q == M_UNLOCK2) mode_d = M_BANK;
							end
							default: begin
								mode_d = M_READY;
							end
						endcase
					end else if (status.addr_cmd2) begin
						if (status.data == CMD_UNLOCK2 && mode_q == M_UNLOCK1) begin
							mode_d = M_UNLOCK2;
						end
					end
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			mode_q     <= M_READY;
			size_sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (cfg_valid) begin
				size_sel_q <= cfg_data;
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign read_valid = (state_q == ST_EXEC) && !status.is_write;

endmodule

// File: rtl/flash_backup_command_fsm_unit.sv
// top level of the flash backup command unit
// usage:
// - a request is taken at a rising edge with start high and busy low;
//   command 0 is a read, 1 a write of data at address
// - a read answers with read_data and read_valid high for exactly one
//   cycle, the cycle right after the request is taken; there is no
//   backpressure, the receiver must take it then
// - a write gives no result; busy is also high in the cycle after it
// - every ordinary read or write is captured in idle and finished in exec,
//   using the store's registered read port and its single write port
// - sector erase keeps busy high through a sweep of one 4096-byte sector,
//   chip erase through all MEMORY_BYTES bytes, one erased byte per cycle
//   from the sweep counter
// - after reset the store is filled with FF by a clearing pass over all
//   MEMORY_BYTES bytes while busy is high
// - size_select is written on the cfg channel (cfg_ready is always
//   high) and should change only while the unit is idle
module flash_backup_command_fsm_unit
	import fbc_pkg::*;
#(
	parameter int MEMORY_BYTES = FBC_MEMORY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	// read result
	output logic        read_valid,
	output logic [7:0]  read_data,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	fbc_cmd_t    cmd;
	fbc_status_t status;

	// config register is always writable
	assign cfg_ready = 1'b1;

	fbc_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy),
		.read_valid (read_valid)
	);

	// store plus request latch
	fbc_datapath #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.address   (address),
		.data      (data),
		.cmd       (cmd),
		.status    (status),
		.read_data (read_data)
	);

endmodule

// File: rtl/fbc_checker.sv
// port-level checker for the flash backup command unit, with its bind
`include "flash_backup_command_fsm_unit_defines.svh"

module fbc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic read_valid
);

	`FBC_ASSERT_NOW(a_valid_while_busy, read_valid, busy)
	`FBC_ASSERT_NEXT(a_read_answers, start && !busy && !command, read_valid)
	`FBC_ASSERT_NEXT(a_write_silent, start && !busy && command, !read_valid)
	`FBC_ASSERT_NEXT(a_single_strobe, read_valid, !read_valid && !busy)

endmodule

bind flash_backup_command_fsm_unit fbc_checker u_fbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.read_valid (read_valid)
);

// File: dv/flash_backup_command_fsm_unit_test.sv
// testbench for the flash backup command unit: directed table, random command sequences
`timescale 1ns / 1ps

module flash_backup_command_fsm_unit_test
	import fbc_pkg::*;
();

	// bus access kinds on the command port
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// a byte that no command decode recognizes, sends the fsm back to ready at 5555
	localparam logic [7:0] CMD_UNKNOWN = 8'h77;

	// erases are slow, so the random part only gets so many of them
	localparam int SECTOR_ERASE_BUDGET = 60;
	localparam int CHIP_ERASE_BUDGET   = 2;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 215;
	// size_select per random phase, both settings used more than once
	localparam bit [PHASES-1:0] PHASE_SIZE_SEL = 6'b101101;

	// cycles with no request, result or config write before giving up;
	// covers the clearing pass after reset and a chip erase with margin
	localparam int WATCHDOG_LIMIT = 200000;

	// command sequencer modes, same encoding as the unit's own fsm states
	typedef enum logic [2:0] {
		FM_READY,
		FM_UNLOCK1,
		FM_UNLOCK2,
		FM_CHIPID,
		FM_ERASEPREP,
		FM_WRITEPREP,
		FM_BANK
	} flash_mode_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// one row of the directed table; cfg rows carry the setting in dat[0]
	typedef struct packed {
		row_kind_t   kind;
		logic        cmd;
		logic [15:0] addr;
		logic [7:0]  dat;
		logic        typed;
		logic [7:0]  want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 29;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [15:0] address;
	logic [7:0]  data;
	logic        read_valid;
	logic [7:0]  read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// model of the part: sequencer mode, backing store, part identity
	flash_mode_t flash_mode;
	logic [7:0]  flash_image [FBC_MEMORY_BYTES];
	logic        size_sel_q;
	int          sector_erases;
	int          chip_erases;

	// bytes that reads already taken by the unit still have to return, oldest first
	logic [7:0]  read_bytes_due [$];

	int          error_count;
	int unsigned accepted_items;
	int          sender_idle_pct;
	logic        start_drive;
	int          quiet_cycles;
	logic [15:0] hot_addrs [8];

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// store comes out of reset erased
		'{ROW_REQ, OP_READ,  16'h0000, 8'h00,        1'b1, ERASED_BYTE},
		// unlock and enter chip-id mode, 64K identity
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNLOCK1, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD2, CMD_UNLOCK2, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_ID_ENTER, 1'b0, 8'h00},
		'{ROW_REQ, OP_READ,  16'h0000, 8'h00,        1'b1, ID_MFR_64K},
		'{ROW_REQ, OP_READ,  16'h0001, 8'h00,        1'b1, ID_DEV_64K},
		// erase command while in chip-id mode has no meaning and is dropped
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_ERASE,   1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_ID_EXIT, 1'b0, 8'h00},
		// program all zeros into the top byte
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNLOCK1, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD2, CMD_UNLOCK2, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_PROGRAM, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, 16'hFFFF, 8'h00,        1'b0, 8'h00},
		'{ROW_REQ, OP_READ,  16'hFFFF, 8'h00,        1'b1, 8'h00},
		// sector erase of the top sector wipes it again
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNLOCK1, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD2, CMD_UNLOCK2, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_ERASE,   1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, 16'hF000, CMD_SECT_ERS, 1'b0, 8'h00},
		'{ROW_REQ, OP_READ,  16'hFFFF, 8'h00,        1'b1, ERASED_BYTE},
		// 128K identity, bank command and its bank number write
		'{ROW_CFG, OP_WRITE, 16'h0000, 8'h01,        1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNLOCK1, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD2, CMD_UNLOCK2, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_BANK,    1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, 16'h0000, 8'hFF,        1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNLOCK1, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD2, CMD_UNLOCK2, 1'b0, 8'h00},
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_ID_ENTER, 1'b0, 8'h00},
		'{ROW_REQ, OP_READ,  16'h0000, 8'h00,        1'b1, ID_MFR_128K},
		// unknown byte at 5555 leaves chip-id mode, address 1 reads the store
		'{ROW_REQ, OP_WRITE, ADDR_CMD1, CMD_UNKNOWN, 1'b0, 8'h00},
		'{ROW_REQ, OP_READ,  16'h0001, 8'h00,        1'b0, 8'h00}
	};

	flash_backup_command_fsm_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.address    (address),
		.data       (data),
		.read_valid (read_valid),
		.read_data  (read_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// byte the part returns for a read in the current mode
	function automatic logic [7:0] flash_read_byte(input logic [15:0] addr);
		if (flash_mode == FM_CHIPID && addr == 16'h0000)
			return size_sel_q ? ID_MFR_128K : ID_MFR_64K;
		if (flash_mode == FM_CHIPID && addr == 16'h0001)
			return size_sel_q ? ID_DEV_128K : ID_DEV_64K;
		return flash_image[addr];
	endfunction

	// advance the command sequencer and the store by one bus write
	function automatic void flash_apply_write(input logic [15:0] addr, input logic [7:0] dat);
		if (flash_mode == FM_WRITEPREP) begin
			// byte program takes any address
			flash_image[addr] = dat;
			flash_mode = FM_READY;
		end else if (flash_mode == FM_ERASEPREP && dat == CMD_SECT_ERS) begin
			// sector picked by the top four address bits
			for (int i = 0; i < FBC_SECTOR_BYTES; i++)
				flash_image[int'(addr[15:12]) * FBC_SECTOR_BYTES + i] = ERASED_BYTE;
			sector_erases++;
			flash_mode = FM_READY;
		end else if (flash_mode == FM_BANK && addr == 16'h0000) begin
			// bank number is swallowed, no switching
			flash_mode = FM_READY;
		end else if (addr == ADDR_CMD1) begin
			case (dat)
				CMD_UNLOCK1: if (flash_mode == FM_READY) flash_mode = FM_UNLOCK1;
				CMD_ID_ENTER: if (flash_mode == FM_UNLOCK2) flash_mode = FM_CHIPID;
				CMD_ID_EXIT: if (flash_mode == FM_CHIPID) flash_mode = FM_READY;
				CMD_ERASE: if (flash_mode == FM_UNLOCK2) flash_mode = FM_ERASEPREP;
				CMD_CHIP_ERS: begin
					if (flash_mode == FM_ERASEPREP) begin
						for (int i = 0; i < FBC_MEMORY_BYTES; i++)
							flash_image[i] = ERASED_BYTE;
						chip_erases++;
						flash_mode = FM_READY;
					end
				end
				CMD_PROGRAM: if (flash_mode == FM_UNLOCK2) flash_mode = FM_WRITEPREP;
				CMD_BANK: if (size_sel_q && flash_mode == FM_UNLOCK2) flash_mode = FM_BANK;
				default: flash_mode = FM_READY;
			endcase
		end else if (addr == ADDR_CMD2) begin
			if (dat == CMD_UNLOCK2 && flash_mode == FM_UNLOCK1)
				flash_mode = FM_UNLOCK2;
		end
	endfunction

	// lower start once, never twice in one step
	task automatic drop_start();
		if (start_drive) begin
			start <= 1'b0;
			start_drive = 1'b0;
		end
	endtask

	// present one request and hold it until the unit takes it
	task automatic bus_access(input logic cmd, input logic [15:0] addr, input logic [7:0] dat,
			input logic typed, input logic [7:0] want);
		logic [7:0] wdat;
		wdat = dat;
		// keep erases within budget: an over-budget erase turns into an unknown byte
		if (cmd == OP_WRITE && flash_mode == FM_ERASEPREP) begin
			if (wdat == CMD_SECT_ERS && sector_erases >= SECTOR_ERASE_BUDGET)
				wdat = CMD_UNKNOWN;
			if (addr == ADDR_CMD1 && wdat == CMD_CHIP_ERS && chip_erases >= CHIP_ERASE_BUDGET)
				wdat = CMD_UNKNOWN;
		end
		if (!start_drive) begin
			start <= 1'b1;
			start_drive = 1'b1;
		end
		command <= cmd;
		address <= addr;
		data    <= wdat;
		do @(posedge clk); while (busy);
		// request taken at this edge
		if (cmd == OP_READ)
			read_bytes_due.push_back(typed ? want : flash_read_byte(addr));
		else
			flash_apply_write(addr, wdat);
		accepted_items++;
		// random sender gap, lands on any cycle of the unit's work
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			drop_start();
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic flash_write(input logic [15:0] addr, input logic [7:0] dat);
		bus_access(OP_WRITE, addr, dat, 1'b0, 8'h00);
	endtask

	task automatic flash_read(input logic [15:0] addr);
		bus_access(OP_READ, addr, 8'h00, 1'b0, 8'h00);
	endtask

	// hold off new requests until every read has answered
	task automatic drain_reads();
		drop_start();
		do @(posedge clk); while (read_bytes_due.size() != 0);
	endtask

	// change part identity once the unit is idle
	task automatic write_size_select(input logic value);
		drop_start();
		do @(posedge clk); while (read_bytes_due.size() != 0 || busy);
		// a write leaves busy up in the cycle after it, give it some slack
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_sel_q = value;
	endtask

	// addresses that get programmed, the id addresses, and half the time random noise
	function automatic logic [15:0] pick_address();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return hot_addrs[$urandom_range(7)];
		if (r < 50)
			return 16'($urandom_range(1));
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_command_byte();
		case ($urandom_range(9))
			0: return CMD_UNLOCK1;
			1: return CMD_UNLOCK2;
			2: return CMD_ID_ENTER;
			3: return CMD_ID_EXIT;
			4: return CMD_ERASE;
			5: return CMD_CHIP_ERS;
			6: return CMD_SECT_ERS;
			7: return CMD_PROGRAM;
			8: return CMD_BANK;
			default: return CMD_UNKNOWN;
		endcase
	endfunction

	// stray write, mostly aimed at the command addresses
	task automatic noise_write();
		logic [15:0] addr;
		logic [7:0]  dat;
		case ($urandom_range(2))
			0: addr = ADDR_CMD1;
			1: addr = ADDR_CMD2;
			default: addr = pick_address();
		endcase
		dat = $urandom_range(1) ? pick_command_byte() : 8'($urandom);
		flash_write(addr, dat);
	endtask

	// unlock step that now and then gets broken by a stray write
	task automatic unlock_write(input logic [15:0] addr, input logic [7:0] dat);
		if ($urandom_range(9) == 0)
			noise_write();
		else
			flash_write(addr, dat);
	endtask

	// one random read, stray write or complete command sequence
	task automatic random_sequence();
		int pick;
		int r;
		pick = $urandom_range(99);
		if (pick < 30) begin
			flash_read(pick_address());
		end else if (pick < 40) begin
			noise_write();
		end else begin
			unlock_write(ADDR_CMD1, CMD_UNLOCK1);
			unlock_write(ADDR_CMD2, CMD_UNLOCK2);
			r = $urandom_range(99);
			if (r < 25) begin
				// chip-id session
				unlock_write(ADDR_CMD1, CMD_ID_ENTER);
				repeat ($urandom_range(1, 4))
					flash_read($urandom_range(3) == 0 ? pick_address() : 16'($urandom_range(1)));
				flash_write(ADDR_CMD1, $urandom_range(4) == 0 ? CMD_UNKNOWN : CMD_ID_EXIT);
			end else if (r < 55) begin
				// byte program
				unlock_write(ADDR_CMD1, CMD_PROGRAM);
				flash_write(pick_address(), 8'($urandom));
			end else if (r < 80) begin
				unlock_write(ADDR_CMD1, CMD_ERASE);
				r = $urandom_range(99);
				if (r < 3)
					flash_write(ADDR_CMD1, CMD_CHIP_ERS);
				else if (r < 85)
					flash_write(pick_address(), CMD_SECT_ERS);
				else
					flash_write(ADDR_CMD1, CMD_UNKNOWN);
			end else begin
				// bank command, optionally a write at a nonzero address first
				unlock_write(ADDR_CMD1, CMD_BANK);
				if ($urandom_range(2) == 0)
					flash_write({8'($urandom_range(1, 255)), 8'h00}, 8'($urandom));
				flash_write(16'h0000, 8'($urandom));
			end
		end
	endtask

	// results come for one cycle and cannot be stalled
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && read_valid) begin
			if (read_bytes_due.size() == 0) begin
				$error("read_data: expected nothing, actual %02h", read_data);
				error_count++;
			end else begin
				want = read_bytes_due.pop_front();
				if (read_data !== want) begin
					$error("read_data: expected %02h, actual %02h", want, read_data);
					error_count++;
				end
			end
		end
	end

	// nothing moving for too long means the unit hung
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || read_valid || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = OP_READ;
		address     = 16'h0000;
		data        = 8'h00;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		start_drive = 1'b0;
		error_count = 0;
		quiet_cycles = 0;
		accepted_items = 0;
		sector_erases = 0;
		chip_erases = 0;
		sender_idle_pct = 8;
		flash_mode = FM_READY;
		size_sel_q = 1'b0;
		for (int i = 0; i < FBC_MEMORY_BYTES; i++)
			flash_image[i] = ERASED_BYTE;
		// the two ends of the window plus random spots for program and read traffic
		hot_addrs[0] = 16'h0000;
		hot_addrs[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			hot_addrs[i] = 16'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part; the first request waits out the clearing pass on busy
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_size_select(directed_rows[i].dat[0]);
			else
				bus_access(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].dat,
					directed_rows[i].typed, directed_rows[i].want);
		end

		// random phases: sender gaps light, then heavy, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			sender_idle_pct = (ph < 2) ? 8 : ((ph < 4) ? 48 : 0);
			write_size_select(PHASE_SIZE_SEL[ph]);
			target = accepted_items + ITEMS_PER_PHASE;
			while (accepted_items < target) begin
				random_sequence();
				if ($urandom_range(63) == 0)
					drain_reads();
			end
		end

		// let the last reads come back, then idle before the verdict
		drain_reads();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
